[rtl/core/cfq_pkg.sv]
package cfq_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int READ_WIDTH     = 32;
    localparam int OPCODE_WIDTH   = 2;
    localparam int STATUS_WIDTH   = 2;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_DISPLAY = 2'd3
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_DISPLAY
    } state_t;

    typedef struct packed {
        logic    valid;
        logic    use_data;
        status_t status;
        logic    is_empty;
        logic    is_full;
        logic    last;
    } rsp_t;

endpackage

[rtl/core/circular_fifo_queue_unit.sv]
// The first result of a word appears in the cycle after the accepting edge, and
// each result is shown for exactly one cycle; display results follow back to back.
// Throughput: enqueue, dequeue and peek accept a new word every cycle (busy stays low).
// A display of N entries holds busy until its last entry is read, one entry per cycle
// from the single read port of the storage memory; an empty display gives one result.
// Reset (rst_n, asynchronous) clears state, pointers, counts and result register only.
// The receiver cannot stall; each result must be taken in the cycle it is shown.
module circular_fifo_queue_unit
    import cfq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [OPCODE_WIDTH-1:0]       opcode,
    input  logic signed [31:0]            push_value,
    output logic                          result_valid,
    output logic signed [READ_WIDTH-1:0]  read_value,
    output logic [STATUS_WIDTH-1:0]       status,
    output logic                          is_empty,
    output logic                          is_full,
    output logic                          last
);

    localparam int PTR_W = $clog2(DEPTH);

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    rsp_t                  rsp;

    assign wr_data = DATA_WIDTH'(push_value);

    cfq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .opcode  (opcode),
        .busy    (busy),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rsp     (rsp)
    );

    cfq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign result_valid = rsp.valid;
    assign read_value   = rsp.use_data ? $signed(READ_WIDTH'(rd_data)) : '0;
    assign status       = rsp.status;
    assign is_empty     = rsp.is_empty;
    assign is_full      = rsp.is_full;
    assign last         = rsp.last;

endmodule

[rtl/core/cfq_mem.sv]
module cfq_mem
    import cfq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [DATA_WIDTH-1:0]         wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [DATA_WIDTH-1:0]         rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/cfq_ctrl.sv]
module cfq_ctrl
    import cfq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [OPCODE_WIDTH-1:0]       opcode,
    output logic                          busy,
    output logic                          wr_en,
    output logic [$clog2(DEPTH)-1:0]      wr_addr,
    output logic                          rd_en,
    output logic [$clog2(DEPTH)-1:0]      rd_addr,
    output rsp_t                          rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  disp_ptr_reg, disp_ptr_next;
    logic [CNT_W-1:0]  disp_left_reg, disp_left_next;
    rsp_t              rsp_reg, rsp_next;
    logic              is_empty_now;
    logic              is_full_now;
    op_t               op;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        advance = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    assign op           = op_t'(opcode);
    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == FULL_CNT);
    assign busy         = (state_reg != S_IDLE);
    assign wr_addr      = tail_reg;
    assign rsp          = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            disp_ptr_reg  <= '0;
            disp_left_reg <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            disp_ptr_reg  <= disp_ptr_next;
            disp_left_reg <= disp_left_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        disp_ptr_next  = disp_ptr_reg;
        disp_left_next = disp_left_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        rsp_next       = '0;
        rsp_next.last  = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rsp_next.valid = 1'b1;
                    case (op)
                        OP_ENQUEUE:
                        begin
                            if (is_full_now)
                            begin
                                rsp_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = advance(tail_reg);
                                count_next = count_reg + ONE_CNT;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (is_empty_now)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en             = 1'b1;
                                rsp_next.use_data = 1'b1;
                                head_next         = advance(head_reg);
                                count_next        = count_reg - ONE_CNT;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (is_empty_now)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en             = 1'b1;
                                rsp_next.use_data = 1'b1;
                            end
                        end
                        OP_DISPLAY:
                        begin
                            if (is_empty_now)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en             = 1'b1;
                                rsp_next.use_data = 1'b1;
                                rsp_next.last     = (count_reg == ONE_CNT);
                                disp_ptr_next     = advance(head_reg);
                                disp_left_next    = count_reg - ONE_CNT;
                                if (count_reg != ONE_CNT)
                                begin
                                    state_next = S_DISPLAY;
                                end
                            end
                        end
                        default:
                        begin
                            rsp_next.valid = 1'b0;
                        end
                    endcase
                end
            end
            S_DISPLAY:
            begin
                rd_en             = 1'b1;
                rd_addr           = disp_ptr_reg;
                rsp_next.valid    = 1'b1;
                rsp_next.use_data = 1'b1;
                rsp_next.last     = (disp_left_reg == ONE_CNT);
                disp_ptr_next     = advance(disp_ptr_reg);
                disp_left_next    = disp_left_reg - ONE_CNT;
                if (disp_left_reg == ONE_CNT)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next.is_empty = (count_next == '0);
        rsp_next.is_full  = (count_next == FULL_CNT);
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count exceeds depth");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> rsp_reg.valid)
        else $error("accepted word produced no result");

    a_display_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPLAY) |=> (rsp_reg.valid && rsp_reg.use_data))
        else $error("display cycle produced no entry");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_reg.valid && rsp_reg.status == ST_OVERFLOW) |-> rsp_reg.is_full)
        else $error("overflow reported on a queue that is not full");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp_reg.is_empty && rsp_reg.is_full))
        else $error("queue flagged empty and full at once");

endmodule

[sim/tb.sv]
module tb;
    import cfq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic signed [READ_WIDTH-1:0] read_value;
        status_t                      status;
        logic                         is_empty;
        logic                         is_full;
        logic                         last;
    } queue_result_t;

    typedef struct packed {
        op_t           op;
        logic [31:0]   word;
        logic          fixed_check;
        queue_result_t res;
    } stim_row_t;

    localparam queue_result_t NO_RES    = '0;
    localparam queue_result_t EMPTY_RES = '{32'sd0, ST_EMPTY, 1'b1, 1'b0, 1'b1};
    localparam queue_result_t PUSH_RES  = '{32'sd0, ST_OK, 1'b0, 1'b0, 1'b1};
    localparam queue_result_t OVER_RES  = '{32'sd0, ST_OVERFLOW, 1'b0, 1'b1, 1'b1};

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [OPCODE_WIDTH-1:0] opcode;
    logic signed [31:0]      push_value;
    logic                    result_valid;
    logic signed [READ_WIDTH-1:0] read_value;
    logic [STATUS_WIDTH-1:0] status;
    logic                    is_empty;
    logic                    is_full;
    logic                    last;

    logic          row_fixed;
    queue_result_t row_result;

    logic signed [31:0] model_words [DEPTH];
    int                 model_head;
    int                 model_tail;
    int                 model_count;
    queue_result_t      pending_results [$];

    int          mismatches;
    int          idle_pct;
    int unsigned quiet_cycles;

    stim_row_t directed_rows [0:24] = '{
        '{OP_DEQUEUE, 32'h0000_0000, 1'b1, EMPTY_RES},
        '{OP_PEEK,    32'h0000_0000, 1'b1, EMPTY_RES},
        '{OP_DISPLAY, 32'h0000_0000, 1'b1, EMPTY_RES},
        '{OP_ENQUEUE, 32'h7FFF_FFFF, 1'b1, PUSH_RES},
        '{OP_ENQUEUE, 32'h8000_0000, 1'b1, PUSH_RES},
        '{OP_ENQUEUE, 32'h0000_0000, 1'b1, PUSH_RES},
        '{OP_ENQUEUE, 32'hFFFF_FFFF, 1'b1, PUSH_RES},
        '{OP_PEEK,    32'h0000_0000, 1'b0, NO_RES},
        '{OP_DISPLAY, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_ENQUEUE, 32'h5555_5555, 1'b1, PUSH_RES},
        '{OP_ENQUEUE, 32'hAAAA_AAAA, 1'b1, PUSH_RES},
        '{OP_ENQUEUE, 32'h0000_0001, 1'b1, PUSH_RES},
        '{OP_ENQUEUE, 32'h1234_5678, 1'b0, NO_RES},
        '{OP_ENQUEUE, 32'hDEAD_BEEF, 1'b1, OVER_RES},
        '{OP_DISPLAY, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_PEEK,    32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_DEQUEUE, 32'h0000_0000, 1'b1, EMPTY_RES}
    };

    circular_fifo_queue_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .push_value   (push_value),
        .result_valid (result_valid),
        .read_value   (read_value),
        .status       (status),
        .is_empty     (is_empty),
        .is_full      (is_full),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic queue_result_t make_result(logic signed [31:0] value, status_t st,
                                                  logic is_final);
        queue_result_t r;
        r.read_value = value;
        r.status     = st;
        r.is_empty   = (model_count == 0);
        r.is_full    = (model_count == DEPTH);
        r.last       = is_final;
        return r;
    endfunction

    function automatic void apply_queue_op(op_t op, logic signed [31:0] value);
        int p;
        if (op == OP_ENQUEUE)
        begin
            if (model_count == DEPTH)
            begin
                pending_results.push_back(make_result(32'sd0, ST_OVERFLOW, 1'b1));
            end
            else
            begin
                model_words[model_tail] = value;
                model_tail = (model_tail + 1) % DEPTH;
                model_count++;
                pending_results.push_back(make_result(32'sd0, ST_OK, 1'b1));
            end
        end
        else if (model_count == 0)
        begin
            pending_results.push_back(make_result(32'sd0, ST_EMPTY, 1'b1));
        end
        else if (op == OP_DEQUEUE)
        begin
            p = model_head;
            model_head = (model_head + 1) % DEPTH;
            model_count--;
            pending_results.push_back(make_result(model_words[p], ST_OK, 1'b1));
        end
        else if (op == OP_PEEK)
        begin
            pending_results.push_back(make_result(model_words[model_head], ST_OK, 1'b1));
        end
        else
        begin
            p = model_head;
            for (int i = 0; i < model_count; i++)
            begin
                pending_results.push_back(make_result(model_words[p], ST_OK,
                                                      i == model_count - 1));
                p = (p + 1) % DEPTH;
            end
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        queue_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with nothing pending, read_value", read_value, 32'h0);
        end
        else
        begin
            want = pending_results.pop_front();
            if (read_value !== want.read_value)
                report_mismatch("read_value", read_value, want.read_value);
            if (status !== want.status)
                report_mismatch("status", 32'(status), 32'(want.status));
            if (is_empty !== want.is_empty)
                report_mismatch("is_empty", 32'(is_empty), 32'(want.is_empty));
            if (is_full !== want.is_full)
                report_mismatch("is_full", 32'(is_full), 32'(want.is_full));
            if (last !== want.last)
                report_mismatch("last", 32'(last), 32'(want.last));
        end
    endtask

    // Results are checked before a newly accepted word is predicted, since a result
    // never comes out in the cycle its word is taken.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (result_valid === 1'b1)
                check_result();
            if (start && !busy)
            begin
                apply_queue_op(op_t'(opcode), push_value);
                if (row_fixed)
                begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(row_result);
                end
            end
            if ((start && !busy) || result_valid === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_word(op_t op, logic [31:0] word, logic fixed, queue_result_t res);
        while ($urandom_range(99) < idle_pct)
        begin
            start      <= 1'b0;
            opcode     <= OPCODE_WIDTH'($urandom);
            push_value <= $urandom;
            row_fixed  <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        push_value <= word;
        row_fixed  <= fixed;
        row_result <= res;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int          phase_idle [3];
        int          enq_pct;
        int          pick;
        op_t         op;
        logic [31:0] word;
        phase_idle   = '{0, 61, 7};
        mismatches   = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        model_head   = 0;
        model_tail   = 0;
        model_count  = 0;
        enq_pct      = 50;
        start      <= 1'b0;
        opcode     <= OP_ENQUEUE;
        push_value <= 32'sd0;
        row_fixed  <= 1'b0;
        row_result <= NO_RES;
        rst_n      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].word,
                      directed_rows[i].fixed_check, directed_rows[i].res);

        // Bursts lean toward filling or draining so that both the full and the
        // empty corners come up again and again with the pointers wrapping.
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = phase_idle[ph];
            for (int n = 0; n < 85; n++)
            begin
                if (n % 17 == 0)
                begin
                    case ($urandom_range(2))
                        0: enq_pct = 25;
                        1: enq_pct = 50;
                        default: enq_pct = 80;
                    endcase
                end
                pick = $urandom_range(99);
                if (pick < enq_pct)
                    op = OP_ENQUEUE;
                else if (pick < enq_pct + (100 - enq_pct) * 6 / 10)
                    op = OP_DEQUEUE;
                else if (pick < 92)
                    op = OP_PEEK;
                else
                    op = OP_DISPLAY;
                case ($urandom_range(19))
                    0: word = 32'h0000_0000;
                    1: word = 32'hFFFF_FFFF;
                    2: word = 32'h7FFF_FFFF;
                    3: word = 32'h8000_0000;
                    default: word = $urandom;
                endcase
                send_word(op, word, 1'b0, NO_RES);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
